// ----- sv/chunked_block_pool_allocator_core_macros.svh -----
// Assertion macros shared by the checker of the block pool allocator.
// Depends on nothing; include after the clock and reset names are known.
`ifndef CHUNKED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define CHUNKED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBPA_ASSERT_NOW(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CBPA_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cbpa_pkg.sv -----
// Shared types and constants of the chunked block pool allocator.
// No dependencies; compiled before every module of the block.
`default_nettype none

package cbpa_pkg;

    // Field widths of the request, the result and the registers.
    localparam int OP_W       = 1;
    localparam int CHUNK_W    = 4;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int BPC_W      = 7;
    localparam int LIMIT_W    = 5;
    localparam int TOP_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // Request operations.
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STS_POOL_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BAD_HANDLE  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_EXCESS_FREE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_PER_CHUNK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_LIMIT      = 1'b1;

    // Register reset values.
    localparam logic [BPC_W-1:0]   BPC_RESET   = 7'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic run;
        logic load;
        logic cfg_write;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- sv/chunked_block_pool_allocator_core.sv -----
// A request is latched, runs in EXEC and waits in RESP for the result register.
// A new one is taken only in IDLE or as RESP loads a result, as the free-stack
// read is registered and each request reads the stack tops left by the last.
// Reset clears control state at once; there is no clearing pass, since entries
// above each chunk's written watermark read as their own slot number.
`default_nettype none

module chunked_block_pool_allocator_core #(
    parameter int MAX_CHUNKS = 16,
    parameter int MAX_SLOTS  = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [cbpa_pkg::OP_W-1:0]        operation,
    input  logic [cbpa_pkg::CHUNK_W-1:0]     free_chunk,
    input  logic [cbpa_pkg::SLOT_W-1:0]      free_slot,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [cbpa_pkg::STATUS_W-1:0]    status,
    output logic [cbpa_pkg::CHUNK_W-1:0]     chunk_number,
    output logic [cbpa_pkg::SLOT_W-1:0]      slot_number,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [cbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cbpa_pkg::*;

    dp_cmd_t cmd;

    // Handshake controller.
    cbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Allocator state and free-stack memory.
    cbpa_dp #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .operation    (operation),
        .free_chunk   (free_chunk),
        .free_slot    (free_slot),
        .status       (status),
        .chunk_number (chunk_number),
        .slot_number  (slot_number)
    );

endmodule

`default_nettype wire

// ----- sv/cbpa_ctrl.sv -----
// Controller of the block pool allocator: request and result handshakes.
// Depends on cbpa_pkg; drives the command struct of cbpa_dp.
`default_nettype none

module cbpa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    output cbpa_pkg::dp_cmd_t cmd
);
    import cbpa_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   can_load;
    logic   take;
    logic   load;

    // The result register can take a new result when empty or draining.
    assign can_load  = !out_valid_reg || out_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_ready  = ((state_reg == ST_IDLE) && !cfg_valid)
                    || ((state_reg == ST_RESP) && can_load);
    assign take      = in_valid && in_ready;
    assign load      = (state_reg == ST_RESP) && can_load;
    assign out_valid = out_valid_reg;

    // Commands to the datapath.
    always_comb
    begin
        cmd.take      = take;
        cmd.run       = (state_reg == ST_EXEC);
        cmd.load      = load;
        cmd.cfg_write = cfg_valid && cfg_ready;
    end

    // Next state: a request is executed, then its result is handed over.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (can_load)
                begin
                    state_next = take ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cbpa_dp.sv -----
// Datapath of the block pool allocator: stack tops, free-stack memory, results.
// Depends on cbpa_pkg; controlled by the command struct from cbpa_ctrl.
`default_nettype none

module cbpa_dp #(
    parameter int MAX_CHUNKS = 16,
    parameter int MAX_SLOTS  = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  cbpa_pkg::dp_cmd_t                cmd,
    input  logic [cbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cbpa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [cbpa_pkg::OP_W-1:0]        operation,
    input  logic [cbpa_pkg::CHUNK_W-1:0]     free_chunk,
    input  logic [cbpa_pkg::SLOT_W-1:0]      free_slot,
    output logic [cbpa_pkg::STATUS_W-1:0]    status,
    output logic [cbpa_pkg::CHUNK_W-1:0]     chunk_number,
    output logic [cbpa_pkg::SLOT_W-1:0]      slot_number
);
    import cbpa_pkg::*;

    // Usable chunks and slots, and the index widths they need.
    localparam int NCH       = (MAX_CHUNKS < 16) ? MAX_CHUNKS : 16;
    localparam int NSL       = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam int CW        = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SW        = (NSL > 1) ? $clog2(NSL) : 1;
    localparam int NCH_ENT   = 2 ** CW;
    localparam int MEM_DEPTH = 2 ** (CW + SW);
    localparam logic [BPC_W-1:0]   BPC_CAP   = BPC_W'(NSL);
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = LIMIT_W'(NCH);

    // Configuration registers.
    logic [BPC_W-1:0]   bpc_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [BPC_W-1:0]   bpc_eff;
    logic [LIMIT_W-1:0] limit_eff;

    // Per-chunk state: stack top, written watermark, availability.
    logic [TOP_W-1:0]   top_reg  [NCH_ENT];
    logic [TOP_W-1:0]   top_next [NCH_ENT];
    logic [TOP_W-1:0]   wm_reg   [NCH_ENT];
    logic [TOP_W-1:0]   wm_next  [NCH_ENT];
    logic [NCH_ENT-1:0] avail_reg;
    logic [NCH_ENT-1:0] avail_next;
    logic [LIMIT_W-1:0] open_reg;
    logic [LIMIT_W-1:0] open_next;

    // Latched request.
    logic [OP_W-1:0]    op_reg;
    logic [CHUNK_W-1:0] fchunk_reg;
    logic [SLOT_W-1:0]  fslot_reg;

    // Pending result between execution and hand-over.
    logic [STATUS_W-1:0] pend_status_reg;
    logic [CHUNK_W-1:0]  pend_chunk_reg;
    logic [SLOT_W-1:0]   pend_pos_reg;
    logic                pend_mem_reg;
    logic [STATUS_W-1:0] ex_status;
    logic [CHUNK_W-1:0]  ex_chunk;
    logic [SLOT_W-1:0]   ex_pos;
    logic                ex_mem;

    // Free-stack memory port.
    logic [SLOT_W-1:0]    stack_mem [MEM_DEPTH];
    logic [SLOT_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic                 mem_re;
    logic [CW+SW-1:0]     maddr;
    logic [SLOT_W-1:0]    mem_wdata;

    // Result registers.
    logic [STATUS_W-1:0] status_reg;
    logic [CHUNK_W-1:0]  chunk_number_reg;
    logic [SLOT_W-1:0]   slot_number_reg;

    assign status       = status_reg;
    assign chunk_number = chunk_number_reg;
    assign slot_number  = slot_number_reg;

    // Clamp the configuration to the usable range.
    always_comb
    begin
        priority if (bpc_reg == '0)
        begin
            bpc_eff = BPC_W'(1);
        end
        else if (bpc_reg > BPC_CAP)
        begin
            bpc_eff = BPC_CAP;
        end
        else
        begin
            bpc_eff = bpc_reg;
        end
        priority if (limit_reg == '0)
        begin
            limit_eff = LIMIT_W'(1);
        end
        else if (limit_reg > LIMIT_CAP)
        begin
            limit_eff = LIMIT_CAP;
        end
        else
        begin
            limit_eff = limit_reg;
        end
    end

    // A chunk can serve an allocation when it is open and not full.
    always_comb
    begin
        for (int i = 0; i < NCH_ENT; i++)
        begin
            avail_next[i] = (LIMIT_W'(i) < open_reg) && (top_reg[i] < bpc_eff);
        end
    end

    // Execution of the latched request against the chunk state.
    always_comb
    begin
        logic             found;
        logic [CW-1:0]    sel;
        logic [CW-1:0]    fidx;
        logic [CW-1:0]    nidx;
        logic [TOP_W-1:0] t;
        logic [TOP_W-1:0] tdec;

        found = 1'b0;
        sel   = '0;
        for (int i = NCH_ENT - 1; i >= 0; i--)
        begin
            if (avail_reg[i])
            begin
                found = 1'b1;
                sel   = CW'(i);
            end
        end
        fidx = fchunk_reg[CW-1:0];
        nidx = open_reg[CW-1:0];
        t    = '0;
        tdec = '0;

        top_next  = top_reg;
        wm_next   = wm_reg;
        open_next = open_reg;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        maddr     = '0;
        mem_wdata = fslot_reg;
        ex_status = STS_OK;
        ex_chunk  = '0;
        ex_pos    = '0;
        ex_mem    = 1'b0;

        if (cmd.run)
        begin
            if (op_reg == OP_ALLOC)
            begin
                priority if (found)
                begin
                    // Pop the lowest open chunk that has room.
                    t             = top_reg[sel];
                    maddr         = {sel, t[SW-1:0]};
                    mem_re        = 1'b1;
                    ex_mem        = (t < wm_reg[sel]);
                    ex_pos        = SLOT_W'(t);
                    ex_chunk      = CHUNK_W'(sel);
                    top_next[sel] = t + TOP_W'(1);
                end
                else if (open_reg < limit_eff)
                begin
                    // Open the next chunk; its fresh stack yields slot zero.
                    top_next[nidx] = TOP_W'(1);
                    wm_next[nidx]  = '0;
                    ex_chunk       = CHUNK_W'(nidx);
                    open_next      = open_reg + LIMIT_W'(1);
                end
                else
                begin
                    ex_status = STS_POOL_FULL;
                end
            end
            else
            begin
                priority if (({1'b0, fchunk_reg} >= open_reg)
                          || ({1'b0, fslot_reg} >= bpc_eff))
                begin
                    ex_status = STS_BAD_HANDLE;
                end
                else if (top_reg[fidx] == '0)
                begin
                    ex_status = STS_EXCESS_FREE;
                end
                else
                begin
                    // Push the slot back and raise the watermark if needed.
                    t              = top_reg[fidx];
                    tdec           = t - TOP_W'(1);
                    top_next[fidx] = tdec;
                    mem_we         = 1'b1;
                    maddr          = {fidx, tdec[SW-1:0]};
                    if (t > wm_reg[fidx])
                    begin
                        wm_next[fidx] = t;
                    end
                end
            end
        end
    end

    // Control state with asynchronous reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpc_reg   <= BPC_RESET;
            limit_reg <= LIMIT_RESET;
            open_reg  <= LIMIT_W'(1);
            avail_reg <= '0;
            for (int i = 0; i < NCH_ENT; i++)
            begin
                top_reg[i] <= '0;
                wm_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                unique case (cfg_index)
                    REG_BLOCKS_PER_CHUNK: bpc_reg   <= cfg_data[BPC_W-1:0];
                    REG_CHUNK_LIMIT:      limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:              bpc_reg   <= bpc_reg;
                endcase
            end
            open_reg  <= open_next;
            avail_reg <= avail_next;
            top_reg   <= top_next;
            wm_reg    <= wm_next;
        end
    end

    // Request capture, pending result and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg     <= operation;
            fchunk_reg <= free_chunk;
            fslot_reg  <= free_slot;
        end
        if (cmd.run)
        begin
            pend_status_reg <= ex_status;
            pend_chunk_reg  <= ex_chunk;
            pend_pos_reg    <= ex_pos;
            pend_mem_reg    <= ex_mem;
        end
        if (cmd.load)
        begin
            status_reg       <= pend_status_reg;
            chunk_number_reg <= pend_chunk_reg;
            slot_number_reg  <= pend_mem_reg ? rdata_reg : pend_pos_reg;
        end
    end

    // Free-stack memory: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[maddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= stack_mem[maddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/cbpa_checker.sv -----
// Port-level checker of the block pool allocator, bound to the top level.
// Depends on cbpa_pkg and chunked_block_pool_allocator_core_macros.svh.
`default_nettype none

`include "chunked_block_pool_allocator_core_macros.svh"

module cbpa_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [cbpa_pkg::STATUS_W-1:0]    status,
    input logic [cbpa_pkg::CHUNK_W-1:0]     chunk_number,
    input logic [cbpa_pkg::SLOT_W-1:0]      slot_number,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);
    import cbpa_pkg::*;

    // A stalled result keeps its payload.
    `CBPA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(chunk_number) && $stable(slot_number),
        "stalled result changed")

    // An accepted request keeps the block busy for the following cycle.
    `CBPA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready,
        !in_ready, "request accepted while the previous one executes")

    // No configuration write while a request executes.
    `CBPA_ASSERT_NEXT(a_no_cfg_in_exec, clk, rst_n, in_valid && in_ready,
        !cfg_ready, "configuration taken during execution")

    // A configuration write and a request never share a cycle.
    `CBPA_ASSERT_NOW(a_cfg_excl, clk, rst_n, cfg_valid && cfg_ready,
        !(in_valid && in_ready), "configuration and request in the same cycle")

    // A failed request carries no handle.
    `CBPA_ASSERT_NOW(a_fail_no_handle, clk, rst_n, out_valid && (status != STS_OK),
        (chunk_number == '0) && (slot_number == '0), "failed result carries a handle")

endmodule

bind chunked_block_pool_allocator_core cbpa_checker u_cbpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .chunk_number (chunk_number),
    .slot_number  (slot_number),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

`default_nettype wire
